/* rtl/core/sit_pkg.sv */
package sit_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;
    localparam int INDEX_WIDTH = 4;
    localparam int CNT_WIDTH   = 5;
    localparam int POS_WIDTH   = 5;
    localparam int SLOT_WIDTH  = $clog2(DEPTH);

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]                    req_type;
        logic signed [VALUE_WIDTH-1:0] value;
        logic [INDEX_WIDTH-1:0]        index;
    } t_req;

    typedef struct packed {
        t_status                       status;
        logic [POS_WIDTH-1:0]          position;
        logic signed [VALUE_WIDTH-1:0] read_value;
        logic [CNT_WIDTH-1:0]          count;
    } t_rsp;

    // What one cell hands to its right-hand neighbour.
    typedef struct packed {
        logic                          lt;
        logic signed [VALUE_WIDTH-1:0] entry;
    } t_cell_link;

    // Broadcast to every cell.
    typedef struct packed {
        logic                          shift_en;
        logic signed [VALUE_WIDTH-1:0] key;
    } t_cell_ctrl;

endpackage

/* rtl/core/sit_cell.sv */
module sit_cell (
    input  logic               i_clk,
    input  sit_pkg::t_cell_ctrl i_ctrl,
    input  logic               i_in_range,
    input  sit_pkg::t_cell_link i_left,
    output sit_pkg::t_cell_link o_link
);
    import sit_pkg::*;

    logic signed [VALUE_WIDTH-1:0] r_entry;
    logic signed [VALUE_WIDTH-1:0] n_entry;
    logic                          lt;

    // Occupied and strictly below the key: the new value lands further right.
    assign lt = i_in_range && (r_entry < i_ctrl.key);

    always_comb begin
        priority if (!i_ctrl.shift_en || lt) begin
            n_entry = r_entry;
        end else if (i_left.lt) begin
            n_entry = i_ctrl.key;
        end else begin
            n_entry = i_left.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_link.lt    = lt;
    assign o_link.entry = r_entry;

endmodule

/* rtl/core/sorted_insert_table.sv */
// Sorted insert table: keeps up to DEPTH signed entries in ascending order in a row
// of cells. One request (insert, read, clear) may be accepted per clock; all cells
// compare against the inserted value at once and shift in the same edge, so the next
// item already sees the updated table. Each item gives exactly one result, held in an
// output register; a new item is taken whenever that register is empty or being
// emptied. Inserts go before equal entries; an insert into a full table, or a read at
// or past the count, reports its status and leaves the table unchanged.
module sorted_insert_table (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  sit_pkg::t_req  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output sit_pkg::t_rsp  o_out_data
);
    import sit_pkg::*;

    localparam int READ_SPAN = (DEPTH < (1 << INDEX_WIDTH)) ? DEPTH : (1 << INDEX_WIDTH);

    logic [CNT_WIDTH-1:0] r_count;
    logic [CNT_WIDTH-1:0] n_count;
    logic                 r_out_valid;
    t_rsp                 r_out;
    t_rsp                 n_out;
    logic                 accept;
    logic                 full;
    t_cell_ctrl           ctrl;
    t_cell_link           links [DEPTH+1];
    logic [DEPTH-1:0]     in_range;
    logic [SLOT_WIDTH-1:0] slot;
    logic signed [VALUE_WIDTH-1:0] rd_entry;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_count == CNT_WIDTH'(DEPTH));

    assign ctrl.shift_en = accept && (i_in_data.req_type == REQ_INSERT) && !full;
    assign ctrl.key      = i_in_data.value;

    // Left edge: behave as an occupied cell below every key.
    assign links[0].lt    = 1'b1;
    assign links[0].entry = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cells
        assign in_range[g] = (CNT_WIDTH'(g) < r_count);
        sit_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (ctrl),
            .i_in_range (in_range[g]),
            .i_left     (links[g]),
            .o_link     (links[g+1])
        );
    end

    // Insert slot: the one cell whose left neighbour is below the key and itself is not.
    always_comb begin
        slot = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (links[i].lt && !links[i+1].lt) begin
                slot = slot | SLOT_WIDTH'(i);
            end
        end
    end

    always_comb begin
        rd_entry = '0;
        for (int i = 0; i < READ_SPAN; i++) begin
            if (i_in_data.index == INDEX_WIDTH'(i)) begin
                rd_entry = links[i+1].entry;
            end
        end
    end

    always_comb begin
        n_count          = r_count;
        n_out.status     = ST_DONE;
        n_out.position   = '0;
        n_out.read_value = '0;
        n_out.count      = r_count;
        unique case (i_in_data.req_type)
            REQ_INSERT: begin
                if (full) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_count        = r_count + CNT_WIDTH'(1);
                    n_out.position = POS_WIDTH'(slot);
                    n_out.count    = n_count;
                end
            end
            REQ_READ: begin
                if (CNT_WIDTH'(i_in_data.index) >= r_count) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.read_value = rd_entry;
                end
            end
            REQ_CLEAR: begin
                n_count     = '0;
                n_out.count = '0;
            end
            default: begin
                // unused kind: report the fill, change nothing
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* rtl/core/sit_checker.sv */
module sit_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input sit_pkg::t_rsp o_out_data
);
    import sit_pkg::*;

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.count <= CNT_WIDTH'(DEPTH))
        else $error("count beyond table depth");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL |->
            o_out_data.count == CNT_WIDTH'(DEPTH) && o_out_data.position == '0
            && o_out_data.read_value == '0)
        else $error("full rejection with wrong fields");

    a_range_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_RANGE |->
            o_out_data.read_value == '0 && o_out_data.position == '0)
        else $error("out-of-range read with non-zero fields");

    a_position_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.position != '0 |->
            o_out_data.position < o_out_data.count)
        else $error("insert position past the count");

endmodule

bind sorted_insert_table sit_checker u_sit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
